>>> hdl/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

    // Width of the number accumulator for count and length lines.
    localparam int NUMBER_WIDTH = 32;
    localparam int TOKEN_WIDTH  = 31;
    localparam int ACC_EXT      = NUMBER_WIDTH + 4;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [1:0] TRAILER_BYTES = 2'd2;

    typedef enum logic [2:0] {
        FAIL_NONE       = 3'd0,
        FAIL_LEAD_BYTE  = 3'd1,
        FAIL_NUMBER     = 3'd2,
        FAIL_NEG_COUNT  = 3'd3,
        FAIL_BAD_LENGTH = 3'd4
    } fail_code_t;

    typedef enum logic [6:0] {
        PH_STAR    = 7'b0000001,
        PH_COUNT   = 7'b0000010,
        PH_DOLLAR  = 7'b0000100,
        PH_LEN     = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_TRAILER = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    // One result per accepted byte.
    typedef struct packed {
        logic                   payload_valid;
        logic [7:0]             payload_byte;
        logic [TOKEN_WIDTH-1:0] token_index;
        logic                   token_done;
        logic                   token_null;
        logic                   command_done;
        logic                   failed;
        fail_code_t             fail_code;
    } rrp_result_t;

endpackage

>>> hdl/resp_request_parser.sv
`timescale 1ns / 1ps
// The result of an accepted byte passes through the output stage registers to the master side.
// Throughput: one byte per cycle while the skid is free; parser state is updated in the cycle a byte is taken.
// A two-entry output stage (result register plus skid register) keeps input flowing under stalls.
// Reset: aresetn is synchronous and active low; it returns the parser to the command start
// and empties the output stage.

module resp_request_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] clear

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_byte, [38:8] token_index, [39] token_done,
                                   // [40] token_null, [41] command_done, [42] failed,
                                   // [45:43] fail_code, [47:46] zero
    output logic        m_tuser    // [0] payload_valid
);
    import rrp_pkg::*;

    // A byte is taken whenever the skid register is free; the skid register
    // only fills when the result register is held by the downstream side.
    logic        accept;
    rrp_result_t core_result;

    rrp_result_t out_reg;
    logic        out_valid_reg;
    rrp_result_t skid_reg;
    logic        skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // The core holds all parser state and produces this byte's result.
    rrp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (accept),
        .byte_i   (s_tdata),
        .clear_i  (s_tuser),
        .result_o (core_result)
    );

    // Output stage. When the result register can move, it takes the skid
    // entry first (the skid being full means no byte was accepted), else the
    // fresh result. When it is stalled, a fresh result parks in the skid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= core_result;
            end
        end else if (accept) begin
            skid_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.payload_valid;
    assign m_tdata  = {2'b00,
                       out_reg.fail_code,
                       out_reg.failed,
                       out_reg.command_done,
                       out_reg.token_null,
                       out_reg.token_done,
                       out_reg.token_index,
                       out_reg.payload_byte};

    // The skid register never holds a result unless the result register does.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry present with an empty result register");

    // An error result always carries a nonzero failure code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.failed) |-> (out_reg.fail_code != FAIL_NONE))
        else $error("error result without a failure code");

    // A payload byte never completes a token or a command itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.payload_valid) |->
            (!out_reg.token_done && !out_reg.command_done))
        else $error("payload byte flagged as token or command end");

    // A completed command is never reported together with an error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.command_done) |-> !out_reg.failed)
        else $error("command completion reported in the error state");

endmodule

>>> hdl/rrp_core.sv
`timescale 1ns / 1ps

module rrp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept_i,
    input  logic [7:0]          byte_i,
    input  logic                clear_i,
    output rrp_pkg::rrp_result_t result_o
);
    import rrp_pkg::*;

    localparam logic [ACC_EXT-1:0] HALF = ACC_EXT'(1) << (NUMBER_WIDTH - 1);

    phase_t                  phase_reg, phase_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic                    seen_reg, seen_next;
    logic                    stopped_reg, stopped_next;
    logic                    cr_reg, cr_next;
    logic [TOKEN_WIDTH-1:0]  tokens_left_reg, tokens_left_next;
    logic [TOKEN_WIDTH-1:0]  token_count_reg, token_count_next;
    logic [TOKEN_WIDTH-1:0]  payload_left_reg, payload_left_next;
    logic [1:0]              trailer_reg, trailer_next;
    fail_code_t              error_reg, error_next;

    // Number line datapath: one digit folded in per byte, saturating one
    // past the magnitude limit so that overflow stays visible.
    logic [ACC_EXT-1:0]      limit;
    logic [ACC_EXT-1:0]      acc_times_ten;
    logic [ACC_EXT-1:0]      acc_sat;
    logic                    is_digit;
    logic                    number_ok;
    logic                    acc_zero;
    logic                    acc_one;
    logic [TOKEN_WIDTH-1:0]  tokens_dec;
    logic [TOKEN_WIDTH-1:0]  payload_dec;
    logic [1:0]              trailer_dec;

    assign limit         = neg_reg ? HALF : HALF - ACC_EXT'(1);
    assign is_digit      = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    // Ten times the accumulator is eight times plus two times, then the digit.
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                           {4'b0000, NUMBER_WIDTH'(byte_i - CH_ZERO)};
    assign acc_sat       = (acc_times_ten > limit) ? limit + ACC_EXT'(1) : acc_times_ten;
    assign number_ok     = seen_reg && ({4'b0000, acc_reg} <= limit);
    assign acc_zero      = (acc_reg == '0);
    assign acc_one       = (acc_reg == NUMBER_WIDTH'(1));
    assign tokens_dec    = tokens_left_reg - TOKEN_WIDTH'(1);
    assign payload_dec   = payload_left_reg - TOKEN_WIDTH'(1);
    assign trailer_dec   = trailer_reg - 2'd1;

    always_comb begin
        phase_next        = phase_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        seen_next         = seen_reg;
        stopped_next      = stopped_reg;
        cr_next           = cr_reg;
        tokens_left_next  = tokens_left_reg;
        token_count_next  = token_count_reg;
        payload_left_next = payload_left_reg;
        trailer_next      = trailer_reg;
        error_next        = error_reg;

        result_o               = '0;
        result_o.token_index   = token_count_reg;

        if (clear_i) begin
            phase_next           = PH_STAR;
            acc_next             = '0;
            neg_next             = 1'b0;
            seen_next            = 1'b0;
            stopped_next         = 1'b0;
            cr_next              = 1'b0;
            tokens_left_next     = '0;
            token_count_next     = '0;
            payload_left_next    = '0;
            trailer_next         = '0;
            error_next           = FAIL_NONE;
            result_o.token_index = '0;
        end else begin
            unique case (phase_reg)
                PH_STAR: begin
                    if (byte_i == CH_STAR) begin
                        acc_next             = '0;
                        neg_next             = 1'b0;
                        seen_next            = 1'b0;
                        stopped_next         = 1'b0;
                        cr_next              = 1'b0;
                        token_count_next     = '0;
                        result_o.token_index = '0;
                        phase_next           = PH_COUNT;
                    end else begin
                        phase_next = PH_ERROR;
                        error_next = FAIL_LEAD_BYTE;
                    end
                end
                PH_COUNT, PH_LEN: begin
                    if (cr_reg && (byte_i == CH_LF)) begin
                        // End of the number line: judge the value.
                        cr_next = 1'b0;
                        if (!number_ok) begin
                            phase_next = PH_ERROR;
                            error_next = FAIL_NUMBER;
                        end else if (phase_reg == PH_COUNT) begin
                            if (neg_reg && !acc_zero) begin
                                phase_next = PH_ERROR;
                                error_next = FAIL_NEG_COUNT;
                            end else if (acc_zero) begin
                                result_o.command_done = 1'b1;
                                phase_next            = PH_STAR;
                            end else begin
                                tokens_left_next = TOKEN_WIDTH'(acc_reg);
                                token_count_next = '0;
                                phase_next       = PH_DOLLAR;
                            end
                        end else begin
                            if (neg_reg && acc_one) begin
                                // Null bulk string completes the token at once.
                                result_o.token_null = 1'b1;
                                result_o.token_done = 1'b1;
                                token_count_next    = token_count_reg + TOKEN_WIDTH'(1);
                                tokens_left_next    = tokens_dec;
                                if (tokens_dec == '0) begin
                                    result_o.command_done = 1'b1;
                                    token_count_next      = '0;
                                    phase_next            = PH_STAR;
                                end else begin
                                    phase_next = PH_DOLLAR;
                                end
                            end else if (neg_reg && !acc_zero) begin
                                phase_next = PH_ERROR;
                                error_next = FAIL_BAD_LENGTH;
                            end else if (acc_zero) begin
                                trailer_next = TRAILER_BYTES;
                                phase_next   = PH_TRAILER;
                            end else begin
                                payload_left_next = TOKEN_WIDTH'(acc_reg);
                                phase_next        = PH_PAYLOAD;
                            end
                        end
                    end else if (cr_reg) begin
                        // A lone CR is line text and ends the digits.
                        stopped_next = 1'b1;
                        cr_next      = (byte_i == CH_CR);
                    end else if (byte_i == CH_CR) begin
                        cr_next = 1'b1;
                    end else if (!stopped_reg) begin
                        if (is_digit) begin
                            acc_next  = NUMBER_WIDTH'(acc_sat);
                            seen_next = 1'b1;
                        end else if ((byte_i == CH_MINUS) && !seen_reg && !neg_reg) begin
                            neg_next = 1'b1;
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                PH_DOLLAR: begin
                    if (byte_i == CH_DOLLAR) begin
                        acc_next     = '0;
                        neg_next     = 1'b0;
                        seen_next    = 1'b0;
                        stopped_next = 1'b0;
                        cr_next      = 1'b0;
                        phase_next   = PH_LEN;
                    end else begin
                        phase_next = PH_ERROR;
                        error_next = FAIL_LEAD_BYTE;
                    end
                end
                PH_PAYLOAD: begin
                    result_o.payload_valid = 1'b1;
                    result_o.payload_byte  = byte_i;
                    payload_left_next      = payload_dec;
                    if (payload_dec == '0) begin
                        trailer_next = TRAILER_BYTES;
                        phase_next   = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    trailer_next = trailer_dec;
                    if (trailer_dec == 2'd0) begin
                        result_o.token_done = 1'b1;
                        token_count_next    = token_count_reg + TOKEN_WIDTH'(1);
                        tokens_left_next    = tokens_dec;
                        if (tokens_dec == '0) begin
                            result_o.command_done = 1'b1;
                            token_count_next      = '0;
                            phase_next            = PH_STAR;
                        end else begin
                            phase_next = PH_DOLLAR;
                        end
                    end
                end
                PH_ERROR: begin
                    phase_next = PH_ERROR;
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end

        result_o.failed    = (phase_next == PH_ERROR);
        result_o.fail_code = error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_STAR;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            seen_reg         <= 1'b0;
            stopped_reg      <= 1'b0;
            cr_reg           <= 1'b0;
            tokens_left_reg  <= '0;
            token_count_reg  <= '0;
            payload_left_reg <= '0;
            trailer_reg      <= '0;
            error_reg        <= FAIL_NONE;
        end else if (accept_i) begin
            phase_reg        <= phase_next;
            acc_reg          <= acc_next;
            neg_reg          <= neg_next;
            seen_reg         <= seen_next;
            stopped_reg      <= stopped_next;
            cr_reg           <= cr_next;
            tokens_left_reg  <= tokens_left_next;
            token_count_reg  <= token_count_next;
            payload_left_reg <= payload_left_next;
            trailer_reg      <= trailer_next;
            error_reg        <= error_next;
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the RESP request parser.
// A byte-level parser model runs beside the block. Every byte that the block
// accepts goes through the model, and its prediction or a golden result is queued. Each
// result transaction from the block is compared with the oldest queued result.
module testbench;
    import rrp_pkg::*;

    localparam int SCRIPT_ROWS  = 25;
    localparam int RANDOM_ITEMS = 1625;
    // The receiver freezes once, for a long time, after this many results.
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    // The sender stops once, after this many items, until the block is empty.
    localparam int PAUSE_AT     = 900;
    // The result of a byte is registered in the output stage before it shows up; leave a margin.
    localparam int DRAIN_CYCLES = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    resp_request_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One row of the directed opening. Rows marked golden carry a result that
    // is obvious from the protocol; all other rows are checked against the model.
    typedef struct packed {
        logic [7:0]  data;
        logic        clr;
        logic        golden;
        rrp_result_t result;
    } script_row_t;

    localparam rrp_result_t NO_CHECK = '0;

    script_row_t script [SCRIPT_ROWS];

    // Results predicted for accepted bytes, oldest first.
    rrp_result_t expected_results[$];
    // Bytes of the request being built; bit 8 is the clear flag.
    logic [8:0]  outgoing[$];

    // Parser model state.
    phase_t                  parse_phase;
    logic [NUMBER_WIDTH-1:0] digit_total;
    logic                    minus_seen;
    logic                    has_digit;
    logic                    digits_over;
    logic                    cr_held;
    logic [TOKEN_WIDTH-1:0]  elements_left;
    logic [TOKEN_WIDTH-1:0]  element_ordinal;
    logic [TOKEN_WIDTH-1:0]  bytes_left;
    logic [1:0]              skip_left;
    fail_code_t              sticky_code;

    int unsigned useful_items   = 0;
    int unsigned sent_items     = 0;
    int unsigned clear_items    = 0;
    int unsigned received       = 0;
    int unsigned mismatches     = 0;
    int unsigned commands_seen  = 0;
    int unsigned tokens_seen    = 0;
    int unsigned nulls_seen     = 0;
    int unsigned payload_seen   = 0;
    int unsigned failures_seen  = 0;
    logic        send_calm      = 1'b0;
    logic        paused_once    = 1'b0;

    function automatic rrp_result_t outcome(logic done, logic tnull, logic cmd, fail_code_t code);
        rrp_result_t r;
        r = '0;
        r.token_done   = done;
        r.token_null   = tnull;
        r.command_done = cmd;
        r.failed       = (code != FAIL_NONE);
        r.fail_code    = code;
        return r;
    endfunction

    function automatic void open_number();
        digit_total = '0;
        minus_seen  = 1'b0;
        has_digit   = 1'b0;
        digits_over = 1'b0;
        cr_held     = 1'b0;
    endfunction

    function automatic void reset_parser();
        parse_phase     = PH_STAR;
        open_number();
        elements_left   = '0;
        element_ordinal = '0;
        bytes_left      = '0;
        skip_left       = '0;
        sticky_code     = FAIL_NONE;
    endfunction

    // Largest magnitude that a number line may hold; one more for a negative value.
    function automatic longint number_ceiling();
        longint half;
        half = longint'(1) << (NUMBER_WIDTH - 1);
        return minus_seen ? half : half - 1;
    endfunction

    function automatic void take_char(logic [7:0] c);
        logic [63:0] grown;
        longint      ceiling;
        if (digits_over) begin
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            ceiling = number_ceiling();
            grown = 64'(digit_total) * 10 + 64'(c - CH_ZERO);
            // Saturate just past the limit so that overflow stays visible.
            if (grown > 64'(ceiling)) begin
                grown = 64'(ceiling) + 1;
            end
            digit_total = grown[NUMBER_WIDTH-1:0];
            has_digit   = 1'b1;
        end else if (c == CH_MINUS && !has_digit && !minus_seen) begin
            minus_seen = 1'b1;
        end else begin
            digits_over = 1'b1;
        end
    endfunction

    // True on the LF of a CR LF pair. A lone CR counts as ordinary line text.
    function automatic logic line_closed(logic [7:0] c);
        if (cr_held) begin
            cr_held = 1'b0;
            if (c == CH_LF) begin
                return 1'b1;
            end
            take_char(CH_CR);
        end
        if (c == CH_CR) begin
            cr_held = 1'b1;
            return 1'b0;
        end
        take_char(c);
        return 1'b0;
    endfunction

    function automatic logic read_number(output longint value);
        value = 0;
        if (!has_digit || longint'(digit_total) > number_ceiling()) begin
            return 1'b0;
        end
        value = minus_seen ? -longint'(digit_total) : longint'(digit_total);
        return 1'b1;
    endfunction

    function automatic void raise(fail_code_t code);
        parse_phase = PH_ERROR;
        sticky_code = code;
    endfunction

    // Closes the current element; true when it was the last of the command.
    function automatic logic close_element();
        element_ordinal = element_ordinal + 1'b1;
        elements_left   = elements_left - 1'b1;
        if (elements_left == '0) begin
            element_ordinal = '0;
            parse_phase     = PH_STAR;
            return 1'b1;
        end
        parse_phase = PH_DOLLAR;
        return 1'b0;
    endfunction

    // Advances the model by one byte and returns the result it should produce.
    function automatic rrp_result_t predict_outcome(logic [7:0] c, logic clr);
        rrp_result_t r;
        longint      value;
        r = '0;
        r.token_index = element_ordinal;
        if (clr) begin
            reset_parser();
            r.token_index = '0;
        end else begin
            case (parse_phase)
                PH_STAR: begin
                    if (c == CH_STAR) begin
                        open_number();
                        element_ordinal = '0;
                        r.token_index   = '0;
                        parse_phase     = PH_COUNT;
                    end else begin
                        raise(FAIL_LEAD_BYTE);
                    end
                end
                PH_COUNT: begin
                    if (line_closed(c)) begin
                        if (!read_number(value)) begin
                            raise(FAIL_NUMBER);
                        end else if (value < 0) begin
                            raise(FAIL_NEG_COUNT);
                        end else if (value == 0) begin
                            r.command_done = 1'b1;
                            parse_phase    = PH_STAR;
                        end else begin
                            elements_left   = value[TOKEN_WIDTH-1:0];
                            element_ordinal = '0;
                            parse_phase     = PH_DOLLAR;
                        end
                    end
                end
                PH_DOLLAR: begin
                    if (c == CH_DOLLAR) begin
                        open_number();
                        parse_phase = PH_LEN;
                    end else begin
                        raise(FAIL_LEAD_BYTE);
                    end
                end
                PH_LEN: begin
                    if (line_closed(c)) begin
                        if (!read_number(value)) begin
                            raise(FAIL_NUMBER);
                        end else if (value == -1) begin
                            r.token_null   = 1'b1;
                            r.token_done   = 1'b1;
                            r.command_done = close_element();
                        end else if (value < 0) begin
                            raise(FAIL_BAD_LENGTH);
                        end else if (value == 0) begin
                            skip_left   = TRAILER_BYTES;
                            parse_phase = PH_TRAILER;
                        end else begin
                            bytes_left  = value[TOKEN_WIDTH-1:0];
                            parse_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    bytes_left      = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        skip_left   = TRAILER_BYTES;
                        parse_phase = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    // The two bytes after a payload are skipped without a look.
                    skip_left = skip_left - 1'b1;
                    if (skip_left == '0) begin
                        r.token_done   = 1'b1;
                        r.command_done = close_element();
                    end
                end
                default: begin
                    parse_phase = PH_ERROR;
                end
            endcase
        end
        r.failed    = (parse_phase == PH_ERROR);
        r.fail_code = sticky_code;
        return r;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        outgoing.insert(outgoing.size(), {1'b0, b});
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    function automatic void put_raw_line(string s);
        put_text(s);
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    // Writes a number line in one of several spellings that all mean the same
    // value: leading zeros, text after the digits, a lone CR, or CR CR LF.
    function automatic void put_number_line(longint v);
        int unsigned style;
        style = $urandom_range(0, 7);
        if (style == 0 && v >= 0) begin
            put_text("00");
        end
        put_text($sformatf("%0d", v));
        case (style)
            1: put_text("ab");
            2: begin
                put_byte(CH_CR);
                put_text("7");
            end
            3: put_byte(CH_CR);
            default: ;
        endcase
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void put_element(longint size);
        put_byte(CH_DOLLAR);
        put_number_line(size);
        if (size >= 0) begin
            repeat (size) put_byte(8'($urandom));
            // The trailer is not checked, so now and then it is random junk.
            if ($urandom_range(0, 3) == 0) begin
                put_byte(8'($urandom));
                put_byte(8'($urandom));
            end else begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
        end
    endfunction

    // Builds one request in the outgoing queue. Most are well formed with
    // random content; the rest are broken in one of many ways, or plain noise.
    function automatic void compose_request();
        int unsigned shape;
        int unsigned elements;
        int unsigned pick;
        longint      size;
        logic [7:0]  b;
        string       text;
        shape = $urandom_range(0, 99);
        if (shape < 70) begin
            elements = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            put_byte(CH_STAR);
            put_number_line(elements);
            repeat (elements) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    size = -1;
                end else if (pick == 1) begin
                    size = 0;
                end else if (pick == 2) begin
                    size = $urandom_range(9, 40);
                end else begin
                    size = $urandom_range(1, 8);
                end
                put_element(size);
            end
            // Sometimes a clear lands somewhere inside the command.
            if ($urandom_range(0, 9) == 0) begin
                outgoing.insert($urandom_range(0, outgoing.size() - 1), {1'b1, 8'($urandom)});
            end
        end else if (shape < 95) begin
            case ($urandom_range(0, 9))
                0: begin
                    size = $urandom_range(1, 5);
                    put_byte(CH_STAR);
                    put_number_line(-size);
                end
                1: begin
                    // Minus zero is a count of zero, not a negative count.
                    put_byte(CH_STAR);
                    put_raw_line("-0");
                end
                2: begin
                    case ($urandom_range(0, 4))
                        0: text = "";
                        1: text = "-";
                        2: text = "+3";
                        3: text = "x5";
                        default: text = "--1";
                    endcase
                    put_byte(CH_STAR);
                    put_raw_line(text);
                end
                3: begin
                    case ($urandom_range(0, 2))
                        0: text = "2147483648";
                        1: text = "99999999999";
                        default: text = "-2147483649";
                    endcase
                    put_byte(CH_STAR);
                    put_raw_line(text);
                end
                4: begin
                    case ($urandom_range(0, 2))
                        0: size = -2;
                        1: size = -longint'(32'h8000_0000);
                        default: size = -longint'($urandom_range(2, 1000));
                    endcase
                    put_byte(CH_STAR);
                    put_number_line(1);
                    put_byte(CH_DOLLAR);
                    put_number_line(size);
                end
                5: begin
                    put_byte(CH_STAR);
                    put_number_line(1);
                    put_byte(CH_DOLLAR);
                    put_raw_line("2147483648");
                end
                6: begin
                    b = 8'($urandom);
                    if (b == CH_DOLLAR) begin
                        b = 8'h00;
                    end
                    put_byte(CH_STAR);
                    put_number_line(2);
                    put_byte(b);
                end
                7: begin
                    b = 8'($urandom);
                    if (b == CH_STAR) begin
                        b = 8'h00;
                    end
                    put_byte(b);
                end
                8: begin
                    put_byte(CH_STAR);
                    if ($urandom_range(0, 1) == 0) begin
                        // Largest count; a few null elements and the command stays open.
                        put_number_line(2147483647);
                        repeat ($urandom_range(1, 4)) put_element(-1);
                    end else begin
                        put_number_line(-longint'(32'h8000_0000));
                    end
                end
                default: begin
                    // Largest length; the payload never ends before the next clear.
                    put_byte(CH_STAR);
                    put_number_line(1);
                    put_byte(CH_DOLLAR);
                    put_number_line(2147483647);
                    repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
        end
    endfunction

    // Offers one byte, waits for the handshake and queues the expected result.
    task automatic send_item(logic [7:0] data, logic clr, logic golden, rrp_result_t result);
        int unsigned gap;
        phase_t      prior;
        rrp_result_t predicted;
        if (sent_items % 100 == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
        end
        gap = send_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= clr;
        do @(posedge aclk); while (!s_tready);
        prior     = parse_phase;
        predicted = predict_outcome(data, clr);
        expected_results.insert(expected_results.size(), golden ? result : predicted);
        sent_items++;
        // Bytes swallowed by the sticky error state do not count as stimulus.
        if (prior != PH_ERROR) begin
            useful_items++;
        end
        if (clr) begin
            clear_items++;
        end
        if (predicted.command_done) begin
            commands_seen++;
        end
        if (predicted.token_done) begin
            tokens_seen++;
        end
        if (predicted.token_null) begin
            nulls_seen++;
        end
        if (predicted.payload_valid) begin
            payload_seen++;
        end
        if (predicted.failed && prior != PH_ERROR) begin
            failures_seen++;
        end
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(logic [47:0] data, logic user);
        rrp_result_t want;
        if (expected_results.size() == 0) begin
            $error("result transaction arrived with no byte waiting for it");
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("payload_valid", want.payload_valid, user);
        compare_field("payload_byte", want.payload_byte, data[7:0]);
        compare_field("token_index", want.token_index, data[38:8]);
        compare_field("token_done", want.token_done, data[39]);
        compare_field("token_null", want.token_null, data[40]);
        compare_field("command_done", want.command_done, data[41]);
        compare_field("failed", want.failed, data[42]);
        compare_field("fail_code", want.fail_code, data[45:43]);
    endtask

    // Result side: random stalls per transaction, calm stretches, and one long
    // freeze that fills the output stage and pushes back on the input.
    initial begin
        int unsigned gap;
        logic        calm;
        calm = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (received % 100 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (received == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = calm ? 0 : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result(m_tdata, m_tuser);
            received++;
        end
    end

    // Stimulus: reset, the directed opening, then random requests.
    initial begin
        logic [8:0] item;
        reset_parser();
        script = '{
            // Clear with every data bit set: everything reads zero.
            '{8'hFF,     1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, FAIL_NONE)},
            '{CH_STAR,   1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, FAIL_NONE)},
            '{CH_ZERO,   1'b0, 1'b0, NO_CHECK},
            '{CH_CR,     1'b0, 1'b0, NO_CHECK},
            // A count of zero completes the command on its LF.
            '{CH_LF,     1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b1, FAIL_NONE)},
            '{CH_STAR,   1'b0, 1'b0, NO_CHECK},
            '{"1",       1'b0, 1'b0, NO_CHECK},
            '{CH_CR,     1'b0, 1'b0, NO_CHECK},
            '{CH_LF,     1'b0, 1'b0, NO_CHECK},
            '{CH_DOLLAR, 1'b0, 1'b0, NO_CHECK},
            '{CH_MINUS,  1'b0, 1'b0, NO_CHECK},
            '{"1",       1'b0, 1'b0, NO_CHECK},
            '{CH_CR,     1'b0, 1'b0, NO_CHECK},
            // A length of minus one is a null token, and here the last one.
            '{CH_LF,     1'b0, 1'b1, outcome(1'b1, 1'b1, 1'b1, FAIL_NONE)},
            '{CH_STAR,   1'b0, 1'b0, NO_CHECK},
            '{"1",       1'b0, 1'b0, NO_CHECK},
            '{CH_CR,     1'b0, 1'b0, NO_CHECK},
            '{CH_LF,     1'b0, 1'b0, NO_CHECK},
            '{CH_DOLLAR, 1'b0, 1'b0, NO_CHECK},
            '{CH_ZERO,   1'b0, 1'b0, NO_CHECK},
            '{CH_CR,     1'b0, 1'b0, NO_CHECK},
            '{CH_LF,     1'b0, 1'b0, NO_CHECK},
            // Empty payload: the two trailer bytes are still skipped.
            '{8'h00,     1'b0, 1'b0, NO_CHECK},
            '{8'hFF,     1'b0, 1'b1, outcome(1'b1, 1'b0, 1'b1, FAIL_NONE)},
            // Anything but a star at the command start is a lead byte error.
            '{"A",       1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, FAIL_LEAD_BYTE)}
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < SCRIPT_ROWS; row++) begin
            send_item(script[row].data, script[row].clr, script[row].golden, script[row].result);
        end

        while (useful_items < SCRIPT_ROWS + RANDOM_ITEMS) begin
            // Once, stop sending until every queued result has come back.
            if (!paused_once && useful_items >= PAUSE_AT) begin
                paused_once = 1'b1;
                s_tvalid <= 1'b0;
                while (expected_results.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            // An open command or a sticky error is cleared before a new request.
            if (parse_phase != PH_STAR || $urandom_range(0, 19) == 0) begin
                send_item(8'($urandom), 1'b1, 1'b0, NO_CHECK);
            end
            compose_request();
            while (outgoing.size() != 0) begin
                item = outgoing.pop_front();
                send_item(item[7:0], item[8], 1'b0, NO_CHECK);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d bytes sent, %0d of them clears, under random and long stalls.",
                 sent_items, clear_items);
        $display("Parsed %0d commands, %0d tokens (%0d null), %0d payload bytes, %0d errors.",
                 commands_seen, tokens_seen, nulls_seen, payload_seen, failures_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("resp_request_parser: match");
        end else begin
            $display("resp_request_parser: mismatch");
        end
        $finish;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial begin
        #5_000_000;
        $display("resp_request_parser: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rrp_pkg.sv
hdl/rrp_core.sv
hdl/resp_request_parser.sv
test/testbench.sv
